### src/gnbt_pkg.sv
// ----------------------------------------------------------------------------
// gnbt_pkg
// Shared types, sizes and codes for the greedy nearest blob tracker.
// ----------------------------------------------------------------------------
package gnbt_pkg;

  localparam int MAX_TRACKS     = 16;
  localparam int MAX_CANDIDATES = 16;
  localparam int RESULT_LIMIT   = 16;

  localparam int T_IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int T_CNT_W = $clog2(MAX_TRACKS + 1);
  localparam int C_IDX_W = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
  localparam int C_CNT_W = $clog2(MAX_CANDIDATES + 1);
  localparam int R_CNT_W = $clog2(RESULT_LIMIT + 1);

  localparam logic [1:0] MODE_CAND  = 2'd0;
  localparam logic [1:0] MODE_END   = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PERSIST    = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [15:0] cand_x;
    logic signed [15:0] cand_y;
    logic signed [15:0] cand_z;
    logic               last_in_frame;
    logic [31:0]        frame_time_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] track_x;
    logic signed [15:0] track_y;
    logic signed [15:0] track_z;
    logic               track_valid;
    logic               last_of_frame;
    logic               dropped;
  } out_item_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } pos_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_START, OP_DIST, OP_COMMIT,
    OP_APPEND, OP_COMPACT, OP_SHRINK, OP_EMIT, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t             op;
    logic [T_CNT_W-1:0] ti;
    logic [C_CNT_W-1:0] ci;
    logic [1:0]         ph;
  } cmd_t;

  typedef struct packed {
    logic [T_CNT_W-1:0] track_count;
    logic [C_CNT_W-1:0] cand_count;
    logic               out_free;
    logic               emit_stall;
  } sts_t;

endpackage

### src/gnbt_ctrl.sv
// ----------------------------------------------------------------------------
// gnbt_ctrl
// Sequencer: walks the association, append, compaction and report loops.
// ----------------------------------------------------------------------------
module gnbt_ctrl import gnbt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_ready,
  input  sts_t     sts,
  output cmd_t     cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b00000001,
    S_START   = 8'b00000010,
    S_ASSOC   = 8'b00000100,
    S_COMMIT  = 8'b00001000,
    S_APPEND  = 8'b00010000,
    S_COMPACT = 8'b00100000,
    S_EMIT    = 8'b01000000,
    S_FINISH  = 8'b10000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [T_CNT_W-1:0] t_r, t_nxt;
  logic [C_CNT_W-1:0] c_r, c_nxt;
  logic [1:0]         ph_r, ph_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      t_r     <= '0;
      c_r     <= '0;
      ph_r    <= '0;
    end else begin
      state_r <= state_nxt;
      t_r     <= t_nxt;
      c_r     <= c_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    t_nxt     = t_r;
    c_nxt     = c_r;
    ph_nxt    = ph_r;
    in_ready  = 1'b0;
    cmd.op    = OP_NONE;
    cmd.ti    = t_r;
    cmd.ci    = c_r;
    cmd.ph    = ph_r;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if ((in_data.mode == MODE_CAND && in_data.last_in_frame) ||
              in_data.mode == MODE_END) begin
            state_nxt = S_START;
          end
        end
      end
      S_START: begin
        cmd.op    = OP_START;
        t_nxt     = '0;
        c_nxt     = '0;
        ph_nxt    = '0;
        state_nxt = S_ASSOC;
      end
      S_ASSOC: begin
        if (t_r == sts.track_count) begin
          c_nxt     = '0;
          state_nxt = S_APPEND;
        end else if (c_r == sts.cand_count) begin
          state_nxt = S_COMMIT;
        end else begin
          // four phases per pair: three axis squares, then compare
          cmd.op = OP_DIST;
          if (ph_r == 2'd3) begin
            ph_nxt = '0;
            c_nxt  = c_r + C_CNT_W'(1);
          end else begin
            ph_nxt = ph_r + 2'd1;
          end
        end
      end
      S_COMMIT: begin
        cmd.op    = OP_COMMIT;
        t_nxt     = t_r + T_CNT_W'(1);
        c_nxt     = '0;
        state_nxt = S_ASSOC;
      end
      S_APPEND: begin
        if (c_r == sts.cand_count) begin
          t_nxt     = '0;
          state_nxt = S_COMPACT;
        end else begin
          cmd.op = OP_APPEND;
          c_nxt  = c_r + C_CNT_W'(1);
        end
      end
      S_COMPACT: begin
        if (t_r == sts.track_count) begin
          cmd.op    = OP_SHRINK;
          t_nxt     = '0;
          state_nxt = S_EMIT;
        end else begin
          cmd.op = OP_COMPACT;
          t_nxt  = t_r + T_CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (t_r == sts.track_count) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.op = OP_EMIT;
          if (!sts.emit_stall) t_nxt = t_r + T_CNT_W'(1);
        end
      end
      S_FINISH: begin
        cmd.op = OP_FINISH;
        if (sts.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

### src/gnbt_dp.sv
// ----------------------------------------------------------------------------
// gnbt_dp
// Candidate and track stores, distance unit, config registers, result stage.
// ----------------------------------------------------------------------------
module gnbt_dp import gnbt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_item_t             in_data,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  pos_t                 cand_mem [MAX_CANDIDATES];
  logic [MAX_CANDIDATES-1:0] taken_r;
  logic [C_CNT_W-1:0]   cand_cnt_r;
  pos_t                 trk_pos [MAX_TRACKS];
  logic [7:0]           trk_hits [MAX_TRACKS];
  logic [31:0]          trk_seen [MAX_TRACKS];
  logic [T_CNT_W-1:0]   trk_cnt_r;
  logic                 drop_r;

  logic [15:0]          md_r;
  logic [31:0]          to_r;
  logic [7:0]           pers_r;
  logic [31:0]          limit_r;
  logic [31:0]          sq_r;
  logic [33:0]          acc_r;
  logic [33:0]          best_r;
  logic [C_IDX_W-1:0]   bidx_r;
  logic                 found_r;
  logic [31:0]          now_r;
  logic [T_CNT_W-1:0]   wn_r;
  logic [R_CNT_W-1:0]   ecnt_r;
  logic                 pend_valid_r;
  pos_t                 pend_r;
  logic                 out_valid_r;
  out_item_t            out_r;

  logic [C_IDX_W-1:0]   ci_idx, crd_idx;
  logic [T_IDX_W-1:0]   ti_idx;
  pos_t                 cand_q, trk_q;
  logic [7:0]           hits_q;
  logic [31:0]          seen_q, age;
  logic signed [15:0]   ca, ta;
  logic signed [16:0]   diff;
  logic signed [33:0]   prod;
  logic [33:0]          total, thresh;
  logic                 keep, persist, out_free, push, cand_full, trk_full;
  out_item_t            push_item;

  assign ci_idx  = cmd.ci[C_IDX_W-1:0];
  assign ti_idx  = cmd.ti[T_IDX_W-1:0];
  assign crd_idx = (cmd.op == OP_COMMIT) ? bidx_r : ci_idx;
  assign cand_q  = cand_mem[crd_idx];
  assign trk_q   = trk_pos[ti_idx];
  assign hits_q  = trk_hits[ti_idx];
  assign seen_q  = trk_seen[ti_idx];

  always_comb begin
    unique case (cmd.ph)
      2'd0:    begin ca = cand_q.x; ta = trk_q.x; end
      2'd1:    begin ca = cand_q.y; ta = trk_q.y; end
      default: begin ca = cand_q.z; ta = trk_q.z; end
    endcase
  end

  assign diff   = {ca[15], ca} - {ta[15], ta};
  assign prod   = diff * diff;
  assign total  = acc_r + {2'b00, sq_r};
  assign thresh = found_r ? best_r : {2'b00, limit_r};
  assign age    = now_r - seen_q;
  assign keep   = (age <= to_r);
  assign persist   = (hits_q >= pers_r) && (ecnt_r < R_CNT_W'(RESULT_LIMIT));
  assign out_free  = !out_valid_r || out_ready;
  assign cand_full = (cand_cnt_r >= C_CNT_W'(MAX_CANDIDATES));
  assign trk_full  = (trk_cnt_r >= T_CNT_W'(MAX_TRACKS));

  // a found track waits in pend_r until we know whether it closes the frame
  always_comb begin
    push = 1'b0;
    push_item.track_x       = pend_r.x;
    push_item.track_y       = pend_r.y;
    push_item.track_z       = pend_r.z;
    push_item.track_valid   = 1'b1;
    push_item.last_of_frame = 1'b0;
    push_item.dropped       = drop_r;
    if (cmd.op == OP_EMIT) begin
      push = persist && pend_valid_r && out_free;
    end else if (cmd.op == OP_FINISH) begin
      push = out_free;
      push_item.last_of_frame = 1'b1;
      if (!pend_valid_r) begin
        push_item.track_x     = '0;
        push_item.track_y     = '0;
        push_item.track_z     = '0;
        push_item.track_valid = 1'b0;
      end
    end
  end

  assign sts.track_count = trk_cnt_r;
  assign sts.cand_count  = cand_cnt_r;
  assign sts.out_free    = out_free;
  assign sts.emit_stall  = persist && pend_valid_r && !out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // stores (no reset)
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD && in_data.mode == MODE_CAND && !cand_full) begin
      cand_mem[cand_cnt_r[C_IDX_W-1:0]] <= '{x: in_data.cand_x, y: in_data.cand_y,
                                            z: in_data.cand_z};
    end
    unique case (cmd.op)
      OP_COMMIT: begin
        if (found_r) begin
          trk_pos[ti_idx]  <= cand_q;
          trk_hits[ti_idx] <= (hits_q == 8'hFF) ? hits_q : hits_q + 8'd1;
          trk_seen[ti_idx] <= now_r;
        end
      end
      OP_APPEND: begin
        if (!taken_r[ci_idx] && !trk_full) begin
          trk_pos[trk_cnt_r[T_IDX_W-1:0]]  <= cand_q;
          trk_hits[trk_cnt_r[T_IDX_W-1:0]] <= 8'd1;
          trk_seen[trk_cnt_r[T_IDX_W-1:0]] <= now_r;
        end
      end
      OP_COMPACT: begin
        if (keep) begin
          trk_pos[wn_r[T_IDX_W-1:0]]  <= trk_q;
          trk_hits[wn_r[T_IDX_W-1:0]] <= hits_q;
          trk_seen[wn_r[T_IDX_W-1:0]] <= seen_q;
        end
      end
      default: ;
    endcase
  end

  // distance unit and payload registers
  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) now_r <= in_data.frame_time_ms;
    if (cmd.op == OP_START) limit_r <= 32'(md_r) * 32'(md_r);
    if (cmd.op == OP_DIST) begin
      sq_r <= prod[31:0];
      if (cmd.ph == 2'd0) acc_r <= '0;
      else                acc_r <= total;
      if (cmd.ph == 2'd3 && !taken_r[ci_idx] && total < thresh) begin
        best_r <= total;
        bidx_r <= ci_idx;
      end
    end
    if (cmd.op == OP_EMIT && persist && (!pend_valid_r || out_free)) pend_r <= trk_q;
    if (push) out_r <= push_item;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      md_r         <= 16'd300;
      to_r         <= 32'd1000;
      pers_r       <= 8'd3;
      cand_cnt_r   <= '0;
      taken_r      <= '0;
      trk_cnt_r    <= '0;
      drop_r       <= 1'b0;
      found_r      <= 1'b0;
      wn_r         <= '0;
      ecnt_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MATCH_DIST: md_r   <= cfg_data[15:0];
          CFG_TIMEOUT:    to_r   <= cfg_data;
          CFG_PERSIST:    pers_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (push) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (cmd.op)
        OP_LOAD: begin
          if (in_data.mode == MODE_CAND) begin
            if (cand_full) begin
              drop_r <= 1'b1;
            end else begin
              taken_r[cand_cnt_r[C_IDX_W-1:0]] <= 1'b0;
              cand_cnt_r <= cand_cnt_r + C_CNT_W'(1);
            end
          end else if (in_data.mode == MODE_CLEAR) begin
            trk_cnt_r <= '0;
          end
        end
        OP_START: begin
          found_r <= 1'b0;
          wn_r    <= '0;
        end
        OP_DIST: begin
          if (cmd.ph == 2'd3 && !taken_r[ci_idx] && total < thresh) found_r <= 1'b1;
        end
        OP_COMMIT: begin
          if (found_r) taken_r[bidx_r] <= 1'b1;
          found_r <= 1'b0;
        end
        OP_APPEND: begin
          if (!taken_r[ci_idx]) begin
            if (trk_full) drop_r <= 1'b1;
            else          trk_cnt_r <= trk_cnt_r + T_CNT_W'(1);
          end
        end
        OP_COMPACT: begin
          if (keep) wn_r <= wn_r + T_CNT_W'(1);
        end
        OP_SHRINK: begin
          trk_cnt_r    <= wn_r;
          ecnt_r       <= '0;
          pend_valid_r <= 1'b0;
        end
        OP_EMIT: begin
          if (persist && (!pend_valid_r || out_free)) begin
            pend_valid_r <= 1'b1;
            ecnt_r       <= ecnt_r + R_CNT_W'(1);
          end
        end
        OP_FINISH: begin
          if (out_free) begin
            cand_cnt_r   <= '0;
            taken_r      <= '0;
            drop_r       <= 1'b0;
            pend_valid_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

### src/greedy_nearest_blob_tracker.sv
// ----------------------------------------------------------------------------
// greedy_nearest_blob_tracker
// Buffers a frame's blob candidates, greedily associates them with stored
// tracks, ages out stale tracks and reports the persistent ones.
//
//   channel  direction  payload      handshake
//   in_      input      in_item_t    in_valid / in_ready
//   out_     output     out_item_t   out_valid / out_ready
//   cfg_     input      index, data  cfg_valid / cfg_ready (always ready)
//
// A frame end runs association with the single shared distance unit (one
// axis square per cycle, then compare), then the append, compaction and
// report passes.
// Results leave through one output register; reporting stalls while it is
// full. Reset (synchronous, rst_n low) empties both stores and loads the
// register defaults.
// ----------------------------------------------------------------------------
module greedy_nearest_blob_tracker import gnbt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  gnbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  gnbt_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the greedy nearest blob tracker: directed frames
// from a table, then random frames, each result checked against a tracker
// model kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;
  import gnbt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG = 200000;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  greedy_nearest_blob_tracker dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of the tracker state
  logic [15:0] mdl_match;
  logic [31:0] mdl_timeout;
  logic [7:0] mdl_persist;
  pos_t cands[MAX_CANDIDATES];
  bit taken[MAX_CANDIDATES];
  int n_cands;
  pos_t trk_pos[MAX_TRACKS];
  int trk_hits[MAX_TRACKS];
  logic [31:0] trk_seen[MAX_TRACKS];
  int n_tracks;
  bit drop_pend;

  out_item_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_frames = 0;
  int send_idle = 33;
  int recv_idle = 60;
  bit hold_recv = 1'b0;
  int quiet = 0;

  function automatic longint sq_dist(pos_t a, pos_t b);
    longint dx, dy, dz;
    dx = longint'(a.x) - longint'(b.x);
    dy = longint'(a.y) - longint'(b.y);
    dz = longint'(a.z) - longint'(b.z);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic void queue_result(out_item_t r);
    expected_q = {expected_q, r};
  endfunction

  task automatic associate_frame(logic [31:0] now);
    longint lim, best, d;
    int bi, keep, shown;
    bit found;
    out_item_t r;
    lim = longint'(mdl_match) * longint'(mdl_match);
    for (int t = 0; t < n_tracks; t++) begin
      best = lim;
      bi = 0;
      found = 0;
      for (int c = 0; c < n_cands; c++) begin
        if (!taken[c]) begin
          d = sq_dist(cands[c], trk_pos[t]);
          if (d < best) begin
            best = d;
            bi = c;
            found = 1;
          end
        end
      end
      if (found) begin
        trk_pos[t] = cands[bi];
        if (trk_hits[t] < 255) trk_hits[t]++;
        trk_seen[t] = now;
        taken[bi] = 1;
      end
    end
    for (int c = 0; c < n_cands; c++) begin
      if (!taken[c]) begin
        if (n_tracks >= MAX_TRACKS) begin
          drop_pend = 1;
        end else begin
          trk_pos[n_tracks] = cands[c];
          trk_hits[n_tracks] = 1;
          trk_seen[n_tracks] = now;
          n_tracks++;
        end
      end
    end
    keep = 0;
    for (int w = 0; w < n_tracks; w++) begin
      if (32'(now - trk_seen[w]) <= mdl_timeout) begin
        trk_pos[keep] = trk_pos[w];
        trk_hits[keep] = trk_hits[w];
        trk_seen[keep] = trk_seen[w];
        keep++;
      end
    end
    n_tracks = keep;
    shown = 0;
    for (int t = 0; t < n_tracks && shown < RESULT_LIMIT; t++) begin
      if (trk_hits[t] >= mdl_persist) begin
        r = '0;
        r.track_x = trk_pos[t].x;
        r.track_y = trk_pos[t].y;
        r.track_z = trk_pos[t].z;
        r.track_valid = 1'b1;
        r.dropped = drop_pend;
        queue_result(r);
        shown++;
      end
    end
    if (shown == 0) begin
      r = '0;
      r.dropped = drop_pend;
      queue_result(r);
    end
    expected_q[$].last_of_frame = 1'b1;
    n_cands = 0;
    taken = '{default: 0};
    drop_pend = 0;
    n_frames++;
  endtask

  task automatic track_item(in_item_t it);
    pos_t p;
    case (it.mode)
      MODE_CAND: begin
        if (n_cands < MAX_CANDIDATES) begin
          p.x = it.cand_x;
          p.y = it.cand_y;
          p.z = it.cand_z;
          cands[n_cands] = p;
          taken[n_cands] = 0;
          n_cands++;
        end else begin
          drop_pend = 1;
        end
        if (it.last_in_frame) associate_frame(it.frame_time_ms);
      end
      MODE_END: associate_frame(it.frame_time_ms);
      MODE_CLEAR: n_tracks = 0;
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] exp);
    $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
    errors++;
  endtask

  // result checking and receiver stalls
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_data.track_x, 16'h0);
      end else begin
        e = expected_q.pop_front();
        if (out_data.track_x !== e.track_x) report_mismatch("x", out_data.track_x, e.track_x);
        if (out_data.track_y !== e.track_y) report_mismatch("y", out_data.track_y, e.track_y);
        if (out_data.track_z !== e.track_z) report_mismatch("z", out_data.track_z, e.track_z);
        if (out_data.track_valid !== e.track_valid)
          report_mismatch("valid", 16'(out_data.track_valid), 16'(e.track_valid));
        if (out_data.last_of_frame !== e.last_of_frame)
          report_mismatch("last", 16'(out_data.last_of_frame), 16'(e.last_of_frame));
        if (out_data.dropped !== e.dropped)
          report_mismatch("dropped", 16'(out_data.dropped), 16'(e.dropped));
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= !hold_recv && ($urandom_range(99) >= recv_idle);
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("watchdog expired with %0d results pending", expected_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // valid stays up after a transaction so the next one can follow at once
  task automatic send_item(in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    track_item(it);
  endtask

  task automatic release_in();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    release_in();
    while (expected_q.size() != 0) @(negedge clk);
    // let the design idle before the next step
    repeat (10) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_MATCH_DIST: mdl_match = val[15:0];
      CFG_TIMEOUT: mdl_timeout = val;
      CFG_PERSIST: mdl_persist = val[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_item_t make_item(logic [1:0] m, int x, int y, int z, bit last,
                                         logic [31:0] tm);
    in_item_t it;
    it.mode = m;
    it.cand_x = 16'(x);
    it.cand_y = 16'(y);
    it.cand_z = 16'(z);
    it.last_in_frame = last;
    it.frame_time_ms = tm;
    return it;
  endfunction

  // one frame around a few tracked blobs that drift, plus clutter
  task automatic random_frame(ref logic [31:0] now, input int base);
    int n;
    in_item_t it;
    now += $urandom_range(400);
    n = $urandom_range(5);
    if ($urandom_range(19) == 0) n = 18;
    if (n == 0) begin
      it = make_item(MODE_END, $urandom, $urandom, $urandom, $urandom_range(1), now);
      send_item(it);
    end else begin
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(3) == 0)
          it = make_item(MODE_CAND, $urandom, $urandom, $urandom, i == n - 1, now);
        else
          it = make_item(MODE_CAND, base + 1000 * (i % 4) + $urandom_range(300) - 150,
                         -base + $urandom_range(200), $urandom_range(100) - 50,
                         i == n - 1, now);
        send_item(it);
      end
    end
    if ($urandom_range(29) == 0) begin
      it = make_item(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom_range(1), $urandom);
      send_item(it);
    end else if ($urandom_range(29) == 0) begin
      it = make_item(MODE_IGNORED, $urandom, $urandom, $urandom, $urandom_range(1), $urandom);
      send_item(it);
    end
  endtask

  // directed stimulus with results typed in where obvious
  typedef struct {
    in_item_t stim;
    bit has_exp;
    out_item_t exp;
  } dir_row_t;

  dir_row_t dir_rows[$];

  function automatic dir_row_t row(in_item_t it, bit he, out_item_t e);
    dir_row_t r;
    r.stim = it;
    r.has_exp = he;
    r.exp = e;
    return r;
  endfunction

  function automatic void add_row(in_item_t it, bit he, out_item_t e);
    dir_rows = {dir_rows, row(it, he, e)};
  endfunction

  initial begin
    logic [31:0] now;
    out_item_t empty_end, big;
    mdl_match = 300;
    mdl_timeout = 1000;
    mdl_persist = 3;
    n_cands = 0;
    n_tracks = 0;
    drop_pend = 0;
    taken = '{default: 0};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    empty_end = '0;
    empty_end.last_of_frame = 1'b1;
    big = '0;
    big.track_x = 16'sh7fff;
    big.track_y = 16'sh8000;
    big.track_z = 16'sh7fff;
    big.track_valid = 1'b1;
    big.last_of_frame = 1'b1;

    // defaults after reset: an empty frame reports the empty marker
    add_row(make_item(MODE_END, 0, 0, 0, 1, 0), 1, empty_end);
    add_row(make_item(MODE_CAND, 32767, -32768, 32767, 1, 10), 1, empty_end);
    add_row(make_item(MODE_CAND, 32767, -32768, 32767, 1, 20), 1, empty_end);
    add_row(make_item(MODE_CAND, 32767, -32768, 32767, 1, 30), 1, big);
    add_row(make_item(MODE_CAND, -32768, 32767, -32768, 0, 40), 0, '0);
    add_row(make_item(MODE_CAND, -32700, 32767, -32768, 0, 40), 0, '0);
    add_row(make_item(MODE_END, 5, 5, 5, 1, 40), 0, '0);
    add_row(make_item(MODE_IGNORED, 1, 2, 3, 1, 50), 0, '0);
    add_row(make_item(MODE_CAND, 32600, -32600, 32767, 1, 1040), 0, '0);
    // timestamp wrap: older tracks go stale
    add_row(make_item(MODE_END, 0, 0, 0, 0, 32'hffff_ff00), 0, '0);
    add_row(make_item(MODE_CAND, 0, 0, 0, 1, 32'h0000_0010), 0, '0);
    add_row(make_item(MODE_CLEAR, 0, 0, 0, 1, 32'hffff_ffff), 0, '0);
    add_row(make_item(MODE_END, 0, 0, 0, 1, 32'h0000_0020), 1, empty_end);
    // tie at equal distance: lower candidate index wins
    add_row(make_item(MODE_CAND, 100, 0, 0, 1, 100), 0, '0);
    add_row(make_item(MODE_CAND, 0, 0, 0, 0, 200), 0, '0);
    add_row(make_item(MODE_CAND, 200, 0, 0, 1, 200), 0, '0);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) begin
        send_item(dir_rows[i].stim);
        // bench model must agree with the typed-in row
        if (expected_q.size() == 0 || expected_q[$] !== dir_rows[i].exp)
          report_mismatch("directed row", 16'(i), 16'h0);
      end else begin
        send_item(dir_rows[i].stim);
      end
    end
    drain();

    // overflow of both stores, persistence 0 and zero match distance
    write_reg(CFG_MATCH_DIST, 32'd0);
    write_reg(CFG_PERSIST, 32'd0);
    write_reg(CFG_TIMEOUT, 32'hffff_ffff);
    now = 32'd5000;
    for (int i = 0; i < 18; i++)
      send_item(make_item(MODE_CAND, i * 7, -i, i, i == 17, now));
    now += 10;
    // store is full, so the lone unmatched candidate is dropped
    send_item(make_item(MODE_CAND, 1, 2, 3, 1, now));
    drain();
    write_reg(CFG_TIMEOUT, 32'd0);
    send_item(make_item(MODE_END, 0, 0, 0, 0, now + 1));
    drain();

    // random frames under three idling regimes
    write_reg(CFG_MATCH_DIST, 32'd400);
    write_reg(CFG_TIMEOUT, 32'd1500);
    write_reg(CFG_PERSIST, 32'd2);
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 33 : (phase == 1) ? 60 : 0;
      recv_idle = (phase == 0) ? 60 : (phase == 1) ? 33 : 0;
      for (int f = 0; f < 6; f++) random_frame(now, $urandom_range(3000) - 1500);
      if (phase == 1) begin
        // receiver holds off while frames keep arriving
        fork
          begin
            hold_recv = 1'b1;
            repeat (3000) @(negedge clk);
            hold_recv = 1'b0;
          end
          begin
            for (int f = 0; f < 3; f++) random_frame(now, 200);
            release_in();
          end
        join
      end
      drain();
      if (phase == 0) begin
        write_reg(CFG_MATCH_DIST, 32'hffff);
        write_reg(CFG_PERSIST, 32'd255);
      end else if (phase == 1) begin
        write_reg(CFG_MATCH_DIST, 32'd300);
        write_reg(CFG_PERSIST, 32'd1);
      end
    end
    for (int f = 0; f < 2; f++) random_frame(now, 0);
    drain();

    $display("covered %0d frames, %0d results checked", n_frames, n_results);
    $display("directed extremes, store overflow, wraparound and three idling regimes");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
